@@ src/skle_pkg.sv @@
// ----------------------------------------------------------------------------
// skle_pkg
// Shared types and constants for the sorted key list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package skle_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_HEAD    = 3'd2;
    localparam logic [OP_W-1:0] OP_TAIL    = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // Broadcast from the controller to every cell of the row
    typedef struct packed {
        logic                    exec;
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic                    ordered;
        logic [CNT_W-1:0]        count;
        logic                    ins_ok;
    } skle_cmd_t;

endpackage

`default_nettype wire

@@ src/skle_cell.sv @@
// ----------------------------------------------------------------------------
// skle_cell
// One list slot: holds a key and payload, compares against the broadcast key,
// passes a "position already found" flag to the next slot and shifts its entry
// towards the head or tail.
// ----------------------------------------------------------------------------
`default_nettype none

module skle_cell (
    input  wire logic                             clk,
    input  wire skle_pkg::skle_cmd_t              cmd,
    input  wire logic [skle_pkg::IDX_W-1:0]       idx,
    input  wire logic                             before_in,
    output logic                                  before_out,
    output logic                                  first,
    input  wire logic signed [skle_pkg::KEY_W-1:0] left_key,
    input  wire logic [skle_pkg::PAY_W-1:0]       left_pay,
    input  wire logic signed [skle_pkg::KEY_W-1:0] right_key,
    input  wire logic [skle_pkg::PAY_W-1:0]       right_pay,
    output logic signed [skle_pkg::KEY_W-1:0]     key_q,
    output logic [skle_pkg::PAY_W-1:0]            pay_q
);
    import skle_pkg::*;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0]        pay_reg, pay_next;
    logic                    valid;
    logic                    at_count;
    logic                    at_tail;
    logic                    sel;
    logic [CNT_W-1:0]        tail_pos;

    assign tail_pos = cmd.count - CNT_W'(1);
    assign valid    = {1'b0, idx} < cmd.count;
    assign at_count = {1'b0, idx} == cmd.count;
    assign at_tail  = {1'b0, idx} == tail_pos;

    always_comb
    begin
        unique case (cmd.op)
            OP_INSERT:
                sel = valid ? (cmd.ordered && (key_reg >= cmd.key)) : at_count;
            OP_REMOVE, OP_SEARCH:
                sel = valid && (key_reg == cmd.key);
            OP_HEAD:
                sel = valid && (idx == '0);
            OP_TAIL:
                sel = valid && at_tail;
            default:
                sel = 1'b0;
        endcase
    end

    assign first      = sel && !before_in;
    assign before_out = before_in || sel;

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (cmd.exec)
        begin
            priority if (cmd.op == OP_INSERT && cmd.ins_ok)
            begin
                // load at the insert point, push later entries one place back
                if (first)
                begin
                    key_next = cmd.key;
                    pay_next = cmd.payload;
                end
                else if (before_in)
                begin
                    key_next = left_key;
                    pay_next = left_pay;
                end
            end
            else if (cmd.op == OP_REMOVE || cmd.op == OP_HEAD)
            begin
                // close the gap from the removed slot onwards
                if (first || before_in)
                begin
                    key_next = right_key;
                    pay_next = right_pay;
                end
            end
            else
            begin
                key_next = key_reg;
                pay_next = pay_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign key_q = key_reg;
    assign pay_q = pay_reg;

endmodule

`default_nettype wire

@@ src/sorted_key_list_engine_core.sv @@
// The command is registered at the accepting edge and executed in S_EXEC; done,
// status and the result are registered together at the end of the execute cycle.
// A new command is accepted only while idle; busy is high for the execute cycle,
// in which the whole cell row compares and shifts at once.
// Reset: entry count and ordered_mode clear to zero; entry contents stay
// undefined until written. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
// sorted_key_list_engine_core
// Bounded key/payload list built from a row of compare-and-shift cells; kept sorted by key in ordered mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_list_engine_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [skle_pkg::OP_W-1:0]         opcode,
    input  wire logic signed [skle_pkg::KEY_W-1:0] key,
    input  wire logic [skle_pkg::PAY_W-1:0]        payload,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_data,
    output logic                                   done,
    output logic [skle_pkg::ST_W-1:0]              status,
    output logic signed [skle_pkg::KEY_W-1:0]      result_key,
    output logic [skle_pkg::PAY_W-1:0]             result_payload,
    output logic [skle_pkg::CNT_W-1:0]             entry_count
);
    import skle_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                    state_reg, state_next;
    logic                    ordered_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [OP_W-1:0]         op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0]        pay_reg;

    logic                    done_reg;
    logic [ST_W-1:0]         status_reg, status_next;
    logic signed [KEY_W-1:0] rkey_reg, rkey_next;
    logic [PAY_W-1:0]        rpay_reg, rpay_next;

    skle_cmd_t               cmd;
    logic                    accept;
    logic                    found;
    logic signed [KEY_W-1:0] hit_key;
    logic [PAY_W-1:0]        hit_pay;

    logic [CAPACITY:0]       hit_chain;
    logic [CAPACITY-1:0]     first;
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [PAY_W-1:0]        cell_pay [CAPACITY];

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.op      = op_reg;
    assign cmd.key     = key_reg;
    assign cmd.payload = pay_reg;
    assign cmd.ordered = ordered_reg;
    assign cmd.count   = count_reg;
    assign cmd.ins_ok  = count_reg < CNT_W'(CAPACITY);

    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int LI = (i == 0) ? 0 : i - 1;
        localparam int RI = (i == CAPACITY - 1) ? i : i + 1;

        skle_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (IDX_W'(i)),
            .before_in  (hit_chain[i]),
            .before_out (hit_chain[i+1]),
            .first      (first[i]),
            .left_key   (cell_key[LI]),
            .left_pay   (cell_pay[LI]),
            .right_key  (cell_key[RI]),
            .right_pay  (cell_pay[RI]),
            .key_q      (cell_key[i]),
            .pay_q      (cell_pay[i])
        );
    end

    // select the data of the first cell that matched (lowest index)
    always_comb
    begin
        hit_key = '0;
        hit_pay = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_key = hit_key | (first[i] ? cell_key[i] : '0);
            hit_pay = hit_pay | (first[i] ? cell_pay[i] : '0);
        end
    end

    assign found = hit_chain[CAPACITY];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = ST_MISS;
        rkey_next   = '0;
        rpay_next   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (cmd.ins_ok)
                        begin
                            status_next = ST_OK;
                            count_next  = count_reg + CNT_W'(1);
                        end
                        else
                            status_next = ST_FULL;
                    end
                    OP_REMOVE, OP_HEAD, OP_TAIL:
                    begin
                        if (found)
                        begin
                            status_next = ST_OK;
                            rkey_next   = hit_key;
                            rpay_next   = hit_pay;
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (found)
                        begin
                            status_next = ST_OK;
                            rkey_next   = hit_key;
                            rpay_next   = hit_pay;
                        end
                    end
                    default:
                        status_next = ST_MISS;
                endcase
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ordered_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= cmd.exec;
            if (cfg_valid && cfg_ready)
                ordered_reg <= cfg_data;
        end
    end

    // hold the command for the execute cycle and register the result at its end
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            pay_reg <= payload;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rkey_reg   <= rkey_next;
            rpay_reg   <= rpay_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign result_key     = rkey_reg;
    assign result_payload = rpay_reg;
    assign entry_count    = count_reg;

endmodule

`default_nettype wire
